// File: design/fpts_pkg.sv
package fpts_pkg;

  // Event kinds carried in s_axis_tuser
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SUSPEND  = 2'd1,
    OP_ACTIVATE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PERIOD_FIRST  = 3'd0,
    REG_PERIOD_SECOND = 3'd1,
    REG_PERIOD_THIRD  = 3'd2,
    REG_OFFSET_FIRST  = 3'd3,
    REG_OFFSET_SECOND = 3'd4,
    REG_OFFSET_THIRD  = 3'd5
  } reg_e;

  localparam int unsigned TimedTasks = 3;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned SigWidth   = 32;
  localparam int unsigned IdWidth    = 3;

  // Reset values of periods and first-release offsets, tasks 0..2
  localparam logic [CfgWidth-1:0] PeriodReset [TimedTasks] = '{16'd10, 16'd2, 16'd7};
  localparam logic [CfgWidth-1:0] OffsetReset [TimedTasks] = '{16'd0, 16'd3, 16'd7};

  // Single-shot tasks and the suspend hand-off pair
  localparam int unsigned ShotTaskA = 1;
  localparam int unsigned ShotTaskB = 2;
  localparam int unsigned PairTaskA = 3;
  localparam int unsigned PairTaskB = 4;

  // Result item as tdata carries it: switch_context is the lowest bit, overrun the highest
  typedef struct packed {
    logic                overrun;
    logic [SigWidth-1:0] signal_out;
    logic [IdWidth-1:0]  entered_task;
    logic [IdWidth-1:0]  left_task;
    logic                create_entered;
    logic                terminate_left;
    logic                switch_context;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);
  localparam int unsigned OutBytes   = (ResultBits + 7) / 8;
  localparam int unsigned InBits     = IdWidth + SigWidth;
  localparam int unsigned InBytes    = (InBits + 7) / 8;

endpackage

// File: design/fpts_pick.sv
// Lowest-numbered ready task wins; idle (index TASK_COUNT) when none is ready.
module fpts_pick #(
  parameter int unsigned TASK_COUNT = 5,
  parameter int unsigned TW         = 3
) (
  input  logic [TASK_COUNT-1:0] ready_i,
  output logic [TW-1:0]         chosen_o
);

  always_comb begin
    chosen_o = TW'(TASK_COUNT);
    for (int j = TASK_COUNT - 1; j >= 0; j--) begin
      if (ready_i[j]) begin
        chosen_o = TW'(j);
      end
    end
  end

endmodule

// File: design/fixed_priority_task_scheduler_unit.sv
// Channel   | Direction | Payload (lowest bit up)
// s_axis    | in        | tuser: op; tdata: task_id, signal (zero-filled to 40 bits)
// m_axis    | out       | tdata: switch_context, terminate_left, create_entered,
//           |           |        left_task, entered_task, signal_out, overrun (48 bits)
// cfg       | in        | cfg_index_i: register index; cfg_data_i: 16-bit value
//
// One event per cycle while s_axis_tready is high; its result is registered
// and appears the cycle after it is taken. Scheduler state updates at that edge.
// s_axis_tready stays high while the result register is empty or being drained.
// Reset: idle task running, periods/offsets at defaults, tick count zero.
// cfg_ready_o is always high; a write to an offset also reloads its release time.
module fixed_priority_task_scheduler_unit #(
  parameter int unsigned TASK_COUNT    = 5,
  parameter int unsigned OVERRUN_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tuser: op[1:0]
  // s_axis_tdata: task_id[2:0], signal[34:3], zero fill
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [1:0]                      s_axis_tuser,
  input  logic [fpts_pkg::InBytes*8-1:0]  s_axis_tdata,
  // m_axis_tdata: switch_context[0], terminate_left[1], create_entered[2],
  //   left_task[5:3], entered_task[8:6], signal_out[40:9], overrun[41], zero fill
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fpts_pkg::OutBytes*8-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [fpts_pkg::CfgWidth-1:0]   cfg_data_i
);

  localparam int unsigned TW = $clog2(TASK_COUNT + 1);
  localparam int unsigned NT = fpts_pkg::TimedTasks;
  localparam int unsigned TM = fpts_pkg::TimeWidth;

  // Scheduler state
  logic [TASK_COUNT-1:0]    ready_q, ready_d;
  logic [TASK_COUNT-1:0]    fresh_q, fresh_d;
  logic [TASK_COUNT-1:0]    ending_q, ending_d;
  logic [OVERRUN_WIDTH-1:0] ovr_cnt_q [TASK_COUNT];
  logic [OVERRUN_WIDTH-1:0] ovr_cnt_d [TASK_COUNT];
  logic [TW-1:0]            run_q, run_d;
  logic [TM-1:0]            tick_q, tick_d;
  logic [TM-1:0]            next_rel_q [NT];
  logic [TM-1:0]            next_rel_d [NT];
  logic [fpts_pkg::CfgWidth-1:0] period_q [NT];

  // Output register
  logic                     out_valid_q;
  fpts_pkg::result_t        result_q, result_d;

  // Input decode
  fpts_pkg::op_e            op;
  logic [fpts_pkg::IdWidth-1:0]  tid;
  logic [fpts_pkg::SigWidth-1:0] sig;
  logic [TW-1:0]            tid_ext;
  logic                     accept;
  logic                     cfg_we;
  logic [NT-1:0]            off_we;

  logic [TASK_COUNT-1:0]    rel_req;
  logic [TASK_COUNT-1:0]    ready_ev;
  logic [TASK_COUNT-1:0]    fresh_ev;
  logic [TASK_COUNT-1:0]    ending_ev;
  logic [TW-1:0]            chosen;
  logic                     ovr;
  logic                     term;
  logic                     create;

  assign op      = fpts_pkg::op_e'(s_axis_tuser);
  assign tid     = s_axis_tdata[fpts_pkg::IdWidth-1:0];
  assign sig     = s_axis_tdata[fpts_pkg::InBits-1:fpts_pkg::IdWidth];
  assign tid_ext = TW'(tid);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i;

  // Release requests: timed tasks on tick, one task on activate
  always_comb begin
    rel_req = '0;
    for (int i = 0; i < NT; i++) begin
      next_rel_d[i] = next_rel_q[i];
    end
    tick_d = tick_q;
    case (op)
      fpts_pkg::OP_TICK: begin
        for (int i = 0; i < NT; i++) begin
          if (tick_q >= next_rel_q[i]) begin
            rel_req[i]    = 1'b1;
            next_rel_d[i] = next_rel_q[i] + TM'(period_q[i]);
          end
        end
        tick_d = tick_q + TM'(1);
      end
      fpts_pkg::OP_ACTIVATE: begin
        for (int j = 0; j < TASK_COUNT; j++) begin
          if (tid_ext == TW'(j)) begin
            rel_req[j] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Event effect on ready/fresh/ending bits and overrun counters
  always_comb begin
    ready_ev  = ready_q;
    fresh_ev  = fresh_q;
    ending_ev = ending_q;
    ovr       = 1'b0;
    for (int j = 0; j < TASK_COUNT; j++) begin
      ovr_cnt_d[j] = ovr_cnt_q[j];
      if (rel_req[j]) begin
        if (ready_q[j]) begin
          ovr = 1'b1;
          if (!(&ovr_cnt_q[j])) begin
            ovr_cnt_d[j] = ovr_cnt_q[j] + OVERRUN_WIDTH'(1);
          end
        end else begin
          ready_ev[j] = 1'b1;
          if (j == fpts_pkg::ShotTaskA || j == fpts_pkg::ShotTaskB) begin
            fresh_ev[j] = 1'b1;
          end
        end
      end
    end
    // Suspend of the running task; ignored while idle runs
    if (op == fpts_pkg::OP_SUSPEND) begin
      for (int j = 0; j < TASK_COUNT; j++) begin
        if (run_q == TW'(j)) begin
          ready_ev[j] = 1'b0;
          if (j == fpts_pkg::ShotTaskA || j == fpts_pkg::ShotTaskB) begin
            ending_ev[j] = 1'b1;
          end else if (j == fpts_pkg::PairTaskA) begin
            ready_ev[fpts_pkg::PairTaskB] = 1'b1;
          end else if (j == fpts_pkg::PairTaskB) begin
            ready_ev[fpts_pkg::PairTaskA] = 1'b1;
          end
        end
      end
    end
  end

  fpts_pick #(
    .TASK_COUNT (TASK_COUNT),
    .TW         (TW)
  ) u_pick (
    .ready_i  (ready_ev),
    .chosen_o (chosen)
  );

  // Switch bookkeeping and result assembly
  always_comb begin
    ready_d  = ready_ev;
    fresh_d  = fresh_ev;
    ending_d = ending_ev;
    run_d    = run_q;
    term     = 1'b0;
    create   = 1'b0;
    if (chosen != run_q) begin
      run_d = chosen;
      for (int j = 0; j < TASK_COUNT; j++) begin
        if (run_q == TW'(j) && ending_ev[j]) begin
          term        = 1'b1;
          ending_d[j] = 1'b0;
        end
        if (chosen == TW'(j) && fresh_ev[j]) begin
          create     = 1'b1;
          fresh_d[j] = 1'b0;
        end
      end
    end
    result_d.switch_context = (chosen != run_q);
    result_d.terminate_left = term;
    result_d.create_entered = create;
    result_d.left_task      = run_q[fpts_pkg::IdWidth-1:0];
    result_d.entered_task   = run_d[fpts_pkg::IdWidth-1:0];
    result_d.signal_out     = (op == fpts_pkg::OP_SUSPEND || op == fpts_pkg::OP_ACTIVATE)
                              ? sig : '0;
    result_d.overrun        = ovr;
  end

  // Offset writes also reload the matching release time
  always_comb begin
    off_we = '0;
    if (cfg_we) begin
      case (fpts_pkg::reg_e'(cfg_index_i))
        fpts_pkg::REG_OFFSET_FIRST:  off_we[0] = 1'b1;
        fpts_pkg::REG_OFFSET_SECOND: off_we[1] = 1'b1;
        fpts_pkg::REG_OFFSET_THIRD:  off_we[2] = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // State registers; the user must write configuration only while no event is in flight (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q  <= '0;
      fresh_q  <= '0;
      ending_q <= '0;
      run_q    <= TW'(TASK_COUNT);
      tick_q   <= '0;
      for (int j = 0; j < TASK_COUNT; j++) begin
        ovr_cnt_q[j] <= '0;
      end
      for (int i = 0; i < NT; i++) begin
        period_q[i]   <= fpts_pkg::PeriodReset[i];
        next_rel_q[i] <= TM'(fpts_pkg::OffsetReset[i]);
      end
    end else begin
      if (accept) begin
        ready_q  <= ready_d;
        fresh_q  <= fresh_d;
        ending_q <= ending_d;
        run_q    <= run_d;
        tick_q   <= tick_d;
        for (int j = 0; j < TASK_COUNT; j++) begin
          ovr_cnt_q[j] <= ovr_cnt_d[j];
        end
      end
      // an offset write takes precedence over the event update
      for (int i = 0; i < NT; i++) begin
        if (off_we[i]) begin
          next_rel_q[i] <= TM'(cfg_data_i);
        end else if (accept) begin
          next_rel_q[i] <= next_rel_d[i];
        end
      end
      if (cfg_we) begin
        case (fpts_pkg::reg_e'(cfg_index_i))
          fpts_pkg::REG_PERIOD_FIRST:  period_q[0] <= cfg_data_i;
          fpts_pkg::REG_PERIOD_SECOND: period_q[1] <= cfg_data_i;
          fpts_pkg::REG_PERIOD_THIRD:  period_q[2] <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = (fpts_pkg::OutBytes*8)'(result_q);

endmodule
